// ===== hw/rtl/hpf_pkg.sv =====
// Shared types and constants of the 7x7 sparse high-pass filter.
package hpf_pkg;

  localparam int MaxWidthDef = 2048;
  localparam int PixW        = 8;
  localparam int DimW        = 12;
  localparam int WinN        = 7;
  localparam int LineRows    = WinN - 1;
  localparam int OfifoDepth  = 8;
  localparam int WidthRst    = 640;
  localparam int HeightRst   = 480;

  localparam logic [PixW-1:0] FillPix = 8'd128;
  localparam logic [DimW-1:0] MinDim  = 12'd7;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } hpf_op_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } hpf_cfg_e;

  typedef logic [WinN-1:0][PixW-1:0] hpf_col_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } hpf_tag_t;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            last;
  } hpf_res_t;

endpackage

// ===== hw/rtl/highpass_7x7_sparse_filter_top.sv =====
// Top level of the 7x7 sparse high-pass filter for raster-order grayscale frames.
//
// Input channel (in_valid_i/in_ready_o): one word per accept, op_i selects a pixel
// word or a drain word. Pixel words feed the line store; once 3*width+3 pixels are
// pending, each pixel word releases the output pixel 3*width+3 positions back in
// raster order. Drain words release one pending output each, or nothing when none
// is pending. Output channel (out_valid_o/out_ready_i) carries the filtered pixel
// and frame_last_o on the last pixel of the frame; border pixels read 128.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes frame width (index 0) or
// height (index 1); any write starts a new frame. Write only while idle.
// Throughput: one word per cycle while in_ready_o is high, bounded by the single
// read-modify-write port of the line store (one column word per cycle). A released
// result passes the line store, window and arithmetic registers to the output queue.
// A stalled receiver fills an 8-entry output queue; input is refused only when
// eight results are in flight or queued, so no result is lost.
// Reset: positions and pending count clear, width 640, height 480; the line store
// is not cleared and needs no clearing pass.
module highpass_7x7_sparse_filter_top #(
  parameter int MAX_WIDTH = hpf_pkg::MaxWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [hpf_pkg::PixW-1:0]    pixel_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hpf_pkg::PixW-1:0]    pixel_out_o,
  output logic                        frame_last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [hpf_pkg::DimW-1:0]    cfg_data_i
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WdW   = ColW + 1;
  localparam int DimW  = hpf_pkg::DimW;
  localparam int CmpW  = (WdW > DimW) ? WdW : DimW;
  localparam int PendW = $clog2(3 * MAX_WIDTH + 4);
  localparam int CredW = $clog2(hpf_pkg::OfifoDepth + 1);
  localparam int WidthRstEff = (hpf_pkg::WidthRst < MAX_WIDTH) ? hpf_pkg::WidthRst : MAX_WIDTH;
  localparam logic [WdW-1:0]   WidthInit  = WdW'(WidthRstEff);
  localparam logic [DimW-1:0]  HeightInit = DimW'(hpf_pkg::HeightRst);
  localparam logic [PendW-1:0] LagInit    = PendW'(3 * WidthRstEff + 3);

  logic [WdW-1:0]   width_q, width_d;
  logic [DimW-1:0]  height_q, height_d;
  logic [PendW-1:0] lag_q, lag_d;
  logic [ColW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [DimW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [PendW-1:0] pending_q, pending_d;
  logic [CredW-1:0] credit_q, credit_d;

  logic [CmpW-1:0]  cfg_wide, cfg_w_sat;
  logic [WdW-1:0]   cfg_w_eff;
  logic [DimW-1:0]  cfg_h_sat;
  logic [PendW-1:0] cfg_lag;
  logic             cfg_acc;

  logic             in_acc, is_pix, emit_ok, emit_go, pop;
  logic             in_col_end, in_row_end, out_col_end, out_row_end, out_inner;
  hpf_pkg::hpf_tag_t tag;

  logic              col_valid;
  hpf_pkg::hpf_col_t col_pix;
  logic              push;
  hpf_pkg::hpf_res_t push_data;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_wide = CmpW'(cfg_data_i);
    if (cfg_wide < CmpW'(hpf_pkg::MinDim)) begin
      cfg_w_sat = CmpW'(hpf_pkg::MinDim);
    end else if (cfg_wide > CmpW'(MAX_WIDTH)) begin
      cfg_w_sat = CmpW'(MAX_WIDTH);
    end else begin
      cfg_w_sat = cfg_wide;
    end
    cfg_w_eff = WdW'(cfg_w_sat);
    cfg_h_sat = (cfg_data_i < hpf_pkg::MinDim) ? hpf_pkg::MinDim : cfg_data_i;
    cfg_lag   = (PendW'(cfg_w_eff) << 1) + PendW'(cfg_w_eff) + PendW'(3);
  end

  assign in_ready_o = (credit_q < CredW'(hpf_pkg::OfifoDepth));
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_pix     = (hpf_pkg::hpf_op_e'(op_i) == hpf_pkg::OP_PIXEL);
  assign emit_ok    = is_pix ? (pending_q >= lag_q) : (pending_q != '0);
  assign emit_go    = in_acc && emit_ok;
  assign pop        = out_valid_o && out_ready_i;

  assign in_col_end  = ((WdW'(in_col_q) + WdW'(1)) == width_q);
  assign in_row_end  = ((in_row_q + DimW'(1)) == height_q);
  assign out_col_end = ((WdW'(out_col_q) + WdW'(1)) == width_q);
  assign out_row_end = ((out_row_q + DimW'(1)) == height_q);
  assign out_inner   = (out_row_q >= DimW'(3))
                    && (((DimW+1)'(out_row_q) + (DimW+1)'(3)) < (DimW+1)'(height_q))
                    && (out_col_q >= ColW'(3))
                    && ((WdW'(out_col_q) + WdW'(3)) < width_q);

  always_comb begin
    tag.emit   = emit_go;
    tag.border = !out_inner;
    tag.last   = out_row_end && out_col_end;
  end

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    lag_d     = lag_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pending_d = pending_q;
    if (cfg_acc) begin
      case (hpf_pkg::hpf_cfg_e'(cfg_index_i))
        hpf_pkg::CFG_WIDTH: begin
          width_d = cfg_w_eff;
          lag_d   = cfg_lag;
        end
        hpf_pkg::CFG_HEIGHT: begin
          height_d = cfg_h_sat;
        end
        default: begin
          width_d = width_q;
        end
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pending_d = '0;
    end else if (in_acc) begin
      if (is_pix) begin
        if (in_col_end) begin
          in_col_d = '0;
          in_row_d = in_row_end ? '0 : in_row_q + DimW'(1);
        end else begin
          in_col_d = in_col_q + ColW'(1);
        end
        if (!emit_ok) begin
          pending_d = pending_q + PendW'(1);
        end
      end else if (emit_ok) begin
        pending_d = pending_q - PendW'(1);
      end
      if (emit_ok) begin
        if (out_col_end) begin
          out_col_d = '0;
          out_row_d = out_row_end ? '0 : out_row_q + DimW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_comb begin
    credit_d = credit_q;
    if (emit_go && !pop) begin
      credit_d = credit_q + CredW'(1);
    end else if (!emit_go && pop) begin
      credit_d = credit_q - CredW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthInit;
      height_q  <= HeightInit;
      lag_q     <= LagInit;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pending_q <= '0;
      credit_q  <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      lag_q     <= lag_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pending_q <= pending_d;
      credit_q  <= credit_d;
    end
  end

  hpf_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_acc && is_pix),
    .col_i       (in_col_q),
    .pix_i       (pixel_in_i),
    .col_valid_o (col_valid),
    .col_pix_o   (col_pix)
  );

  hpf_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_valid_i (col_valid),
    .col_pix_i   (col_pix),
    .tag_i       (tag),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hpf_ofifo u_ofifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= lag_q)
    else $error("pending count exceeds the window lag");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CredW'(hpf_pkg::OfifoDepth))
    else $error("more results in flight than the output queue holds");

  a_silent_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !emit_ok) |-> ##3 !push)
    else $error("result pushed for a word that releases nothing");

endmodule

// ===== hw/rtl/hpf_line_mem.sv =====
// Line store: one word per column holding the six previous rows, read-modify-write.
module hpf_line_mem #(
  parameter int MAX_WIDTH = hpf_pkg::MaxWidthDef,
  localparam int ColW = $clog2(MAX_WIDTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_i,
  input  logic [ColW-1:0]               col_i,
  input  logic [hpf_pkg::PixW-1:0]      pix_i,
  output logic                          col_valid_o,
  output hpf_pkg::hpf_col_t             col_pix_o
);

  localparam int WordW = hpf_pkg::LineRows * hpf_pkg::PixW;

  logic [WordW-1:0]         mem_q [MAX_WIDTH];
  logic [WordW-1:0]         rd_q;
  logic [ColW-1:0]          s1_col_q;
  logic [hpf_pkg::PixW-1:0] s1_pix_q;
  logic                     s1_vld_q;
  logic [WordW-1:0]         wr_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      rd_q     <= mem_q[col_i];
      s1_col_q <= col_i;
      s1_pix_q <= pix_i;
    end
    if (s1_vld_q) begin
      mem_q[s1_col_q] <= wr_word;
    end
  end

  // shift the new row in, drop the oldest
  assign wr_word = {rd_q[WordW-hpf_pkg::PixW-1:0], s1_pix_q};

  always_comb begin
    col_pix_o[hpf_pkg::WinN-1] = s1_pix_q;
    for (int i = 0; i < hpf_pkg::LineRows; i++) begin
      col_pix_o[i] = rd_q[(hpf_pkg::LineRows-1-i)*hpf_pkg::PixW +: hpf_pkg::PixW];
    end
  end

  assign col_valid_o = s1_vld_q;

  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i && s1_vld_q && (col_i == s1_col_q)))
    else $error("line store read hits the column being written back");

endmodule

// ===== hw/rtl/hpf_window.sv =====
// 7x7 window registers and the sparse high-pass arithmetic.
module hpf_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              col_valid_i,
  input  hpf_pkg::hpf_col_t col_pix_i,
  input  hpf_pkg::hpf_tag_t tag_i,
  output logic              push_o,
  output hpf_pkg::hpf_res_t push_data_o
);

  localparam int Last = hpf_pkg::WinN - 1;

  logic [hpf_pkg::WinN-1:0][hpf_pkg::WinN-1:0][hpf_pkg::PixW-1:0] win_q;
  hpf_pkg::hpf_tag_t tag1_q, tag2_q, tag3_q;
  logic [9:0]  s4;
  logic [10:0] s8;
  logic [9:0]  p3;
  logic [5:0]  a_q;
  logic [6:0]  b_q;
  logic [7:0]  c_q;
  logic [hpf_pkg::PixW-1:0] val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_valid_i) begin
      win_q <= {col_pix_i, win_q[hpf_pkg::WinN-1:1]};
    end
    a_q <= s4[9:4];
    b_q <= s8[10:4];
    c_q <= p3[9:2];
  end

  // win_q[column][row]
  always_comb begin
    s4 = 10'(win_q[0][0]) + 10'(win_q[Last][0])
       + 10'(win_q[0][Last]) + 10'(win_q[Last][Last]);
    s8 = 11'(win_q[1][1]) + 11'(win_q[5][1])
       + 11'(win_q[2][2]) + 11'(win_q[4][2])
       + 11'(win_q[2][4]) + 11'(win_q[4][4])
       + 11'(win_q[1][5]) + 11'(win_q[5][5]);
    p3 = {1'b0, win_q[3][3], 1'b0} + 10'(win_q[3][3]);
  end

  assign val = hpf_pkg::FillPix - hpf_pkg::PixW'(a_q) - hpf_pkg::PixW'(b_q) + c_q;

  assign push_o           = tag3_q.emit;
  assign push_data_o.pix  = tag3_q.border ? hpf_pkg::FillPix : val;
  assign push_data_o.last = tag3_q.last;

endmodule

// ===== hw/rtl/hpf_ofifo.sv =====
// Output queue between the filter pipeline and the result channel.
module hpf_ofifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  hpf_pkg::hpf_res_t        push_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [hpf_pkg::PixW-1:0] pixel_out_o,
  output logic                     frame_last_o
);

  localparam int Depth = hpf_pkg::OfifoDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  hpf_pkg::hpf_res_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;

  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_valid_o  = (count_q != '0);
  assign pixel_out_o  = mem_q[rd_ptr_q].pix;
  assign frame_last_o = mem_q[rd_ptr_q].last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop && (count_q == CntW'(Depth))))
    else $error("output queue overflow");

endmodule

// ===== tb/highpass_7x7_sparse_filter_top_test.sv =====
// Self-checking testbench of the 7x7 sparse high-pass filter top level.
`timescale 1ns / 100ps

class hpf_pixel_tracker;
  logic [7:0]        src_rows [7 * hpf_pkg::MaxWidthDef];
  logic [11:0]       width_val;
  logic [11:0]       height_val;
  int unsigned       wr_col, wr_row, rd_col, rd_row, backlog;
  int unsigned       errors;
  hpf_pkg::hpf_res_t pixels_due [$];

  function new();
    width_val  = hpf_pkg::WidthRst;
    height_val = hpf_pkg::HeightRst;
    errors     = 0;
    restart();
  endfunction

  function void restart();
    wr_col  = 0;
    wr_row  = 0;
    rd_col  = 0;
    rd_row  = 0;
    backlog = 0;
  endfunction

  function int unsigned cols();
    int unsigned w;
    w = width_val;
    if (w < 7) w = 7;
    if (w > hpf_pkg::MaxWidthDef) w = hpf_pkg::MaxWidthDef;
    return w;
  endfunction

  function int unsigned rows_per_frame();
    int unsigned h;
    h = height_val;
    if (h < 7) h = 7;
    return h;
  endfunction

  function int unsigned px(int unsigned r, int unsigned c);
    return src_rows[(r % 7) * hpf_pkg::MaxWidthDef + c];
  endfunction

  function void set_reg(hpf_pkg::hpf_cfg_e idx, logic [11:0] val);
    if (idx == hpf_pkg::CFG_WIDTH) begin
      width_val = val;
    end else begin
      height_val = val;
    end
    restart();
  endfunction

  // Queue the filtered pixel at the read position and advance it.
  function void release_pixel();
    int unsigned w, h, r, c, s4, s8, p;
    int v;
    hpf_pkg::hpf_res_t res;
    w = cols();
    h = rows_per_frame();
    r = rd_row;
    c = rd_col;
    v = 128;
    if (r >= 3 && r + 3 < h && c >= 3 && c + 3 < w) begin
      s4 = px(r - 3, c - 3) + px(r - 3, c + 3) + px(r + 3, c - 3) + px(r + 3, c + 3);
      s8 = px(r - 2, c - 2) + px(r - 2, c + 2) + px(r - 1, c - 1) + px(r - 1, c + 1)
         + px(r + 1, c - 1) + px(r + 1, c + 1) + px(r + 2, c - 2) + px(r + 2, c + 2);
      p  = px(r, c);
      v  = 128 - int'(s4 / 16) - int'(s8 / 16) + int'((3 * p) / 4);
    end
    res.pix  = v[7:0];
    res.last = (r + 1 >= h) && (c + 1 >= w);
    pixels_due.push_back(res);
    if (c + 1 >= w) begin
      rd_col = 0;
      rd_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      rd_col = c + 1;
    end
    if (backlog > 0) backlog--;
  endfunction

  function void take_word(hpf_pkg::hpf_op_e op, logic [7:0] pix);
    int unsigned w, h;
    w = cols();
    h = rows_per_frame();
    if (rd_col >= w || rd_row >= h || wr_col >= w || wr_row >= h) restart();
    if (op == hpf_pkg::OP_DRAIN) begin
      if (backlog > 0) release_pixel();
    end else begin
      src_rows[(wr_row % 7) * hpf_pkg::MaxWidthDef + wr_col] = pix;
      if (wr_col + 1 >= w) begin
        wr_col = 0;
        wr_row = (wr_row + 1 >= h) ? 0 : wr_row + 1;
      end else begin
        wr_col++;
      end
      backlog++;
      if (backlog > 3 * w + 3) release_pixel();
    end
  endfunction

  // True when every pending output is a border pixel, so a full drain is defined.
  function bit drain_safe();
    return (wr_col == 0 && wr_row == 0) ||
           (rd_col == 0 && rd_row == 0 && backlog == wr_row * cols() + wr_col);
  endfunction

  function void match_pixel(logic [7:0] pix, logic last);
    hpf_pkg::hpf_res_t want;
    if (pixels_due.size() == 0) begin
      $error("unexpected output word: pixel_out %0d frame_last %0d", pix, last);
      errors++;
    end else begin
      want = pixels_due.pop_front();
      if (pix !== want.pix) begin
        $error("pixel_out mismatch: expected %0d, actual %0d", want.pix, pix);
        errors++;
      end
      if (last !== want.last) begin
        $error("frame_last mismatch: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    end
  endfunction
endclass

module highpass_7x7_sparse_filter_top_test;

  localparam int IdleLimit = 2000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        op_i        = hpf_pkg::OP_PIXEL;
  logic [7:0]  pixel_in_i  = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  pixel_out_o;
  logic        frame_last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = hpf_pkg::CFG_WIDTH;
  logic [11:0] cfg_data_i  = 12'd0;

  hpf_pixel_tracker sb;
  int unsigned      burst_left  = 0;
  int unsigned      hold_cnt    = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      words_sent  = 0;
  bit               tx_steady   = 1'b0;
  bit               rx_steady   = 1'b0;
  bit               rx_level    = 1'b0;

  highpass_7x7_sparse_filter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.match_pixel(pixel_out_o, frame_last_o);
    end
    if (hold_cnt == 0) begin
      rx_level = rx_steady || ($urandom_range(0, 2) != 0);
      hold_cnt = rx_level ? $urandom_range(1, 30) : $urandom_range(1, 12);
    end
    hold_cnt--;
    out_ready_i <= rx_level;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(input hpf_pkg::hpf_op_e op, input logic [7:0] pix);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!tx_steady) gap = $urandom_range(0, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_word(op, pix);
    words_sent++;
  endtask

  task automatic hold_until_empty();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pixels_due.size() != 0);
  endtask

  task automatic flush_backlog(input int unsigned extra);
    while (sb.backlog > 0) send_word(hpf_pkg::OP_DRAIN, rand_pix());
    repeat (extra) send_word(hpf_pkg::OP_DRAIN, rand_pix());
  endtask

  task automatic stream_pixels(input int unsigned n, input bit events);
    repeat (n) begin
      if (events && sb.backlog > 0 && sb.drain_safe() && $urandom_range(0, 15) == 0) begin
        flush_backlog($urandom_range(0, 1));
      end
      if (events && $urandom_range(0, 63) == 0) hold_until_empty();
      send_word(hpf_pkg::OP_PIXEL, rand_pix());
    end
  endtask

  task automatic write_cfg(input hpf_pkg::hpf_cfg_e idx, input logic [11:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  task automatic reconfigure(input logic [11:0] w, input logic [11:0] h,
                             input bit wr_w, input bit wr_h);
    hold_until_empty();
    repeat (12) @(posedge clk_i);
    if (wr_w) write_cfg(hpf_pkg::CFG_WIDTH, w);
    if (wr_h) write_cfg(hpf_pkg::CFG_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned start_words, pick, frames, area;
    logic [11:0] w_val, h_val;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset geometry: a short run of first-row pixels, drained as border words
    stream_pixels(12, 1'b0);
    hold_until_empty();
    flush_backlog(1);

    // smallest frame with one interior pixel, saturated from zero
    reconfigure(12'd0, 12'd0, 1'b1, 1'b1);
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < 49; i++) begin
        send_word(hpf_pkg::OP_PIXEL, (i == 24) ? ((f == 1) ? 8'd0 : 8'd255)
                                               : ((f == 2) ? 8'd0 : 8'd255));
      end
    end
    flush_backlog(2);
    stream_pixels(5, 1'b0);
    flush_backlog(1);

    // saturated width: first-row pixels only, drained as border words
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    reconfigure(12'hfff, 12'd7, 1'b1, 1'b1);
    stream_pixels(24, 1'b0);
    flush_backlog(0);

    // tall narrow frame: reach the first interior rows, abandon the rest
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    reconfigure(12'd7, 12'hfff, 1'b1, 1'b1);
    stream_pixels(7 * 8, 1'b0);

    // widest exact row, frame abandoned with outputs still pending
    reconfigure(12'd2048, 12'd6, 1'b1, 1'b1);
    stream_pixels(20, 1'b0);

    start_words = words_sent;
    while (words_sent - start_words < 100) begin
      case ($urandom_range(0, 7))
        0:       w_val = 12'($urandom_range(0, 6));
        1:       w_val = 12'($urandom_range(15, 40));
        default: w_val = 12'($urandom_range(7, 14));
      endcase
      h_val = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 6))
                                          : 12'($urandom_range(7, 10));
      pick = $urandom_range(1, 3);
      reconfigure(w_val, h_val, pick[0], pick[1]);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      frames    = $urandom_range(1, 2);
      area      = sb.cols() * sb.rows_per_frame();
      stream_pixels(frames * area, 1'b1);
      if ($urandom_range(0, 3) != 0) begin
        flush_backlog($urandom_range(0, 2));
      end else begin
        stream_pixels($urandom_range(1, area - 1), 1'b1);
      end
    end

    hold_until_empty();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hpf_pkg.sv
hw/rtl/hpf_line_mem.sv
hw/rtl/hpf_window.sv
hw/rtl/hpf_ofifo.sv
hw/rtl/highpass_7x7_sparse_filter_top.sv
tb/highpass_7x7_sparse_filter_top_test.sv
